// ===== design/trx_pkg.sv =====
// shared types and constants of the timed-key rolling xor codec
package trx_pkg;

  typedef logic [7:0] trx_byte_t;

  // fixed base key and message framing widths
  localparam int KEY_LEN = 8;
  localparam int KEY_IDX_W = $clog2(KEY_LEN);
  localparam int SIZE_W = $clog2(KEY_LEN) + 1;
  localparam int UPTIME_W = 40;
  localparam trx_byte_t BASE_KEY [KEY_LEN] = '{
    8'h8F, 8'h80, 8'h19, 8'hCF, 8'h77, 8'h6C, 8'hFE, 8'hB7
  };

  // bucket = floor((uptime - 5000) / 10000) = floor(((uptime - 5000) >> 4) / 625)
  localparam logic [UPTIME_W-1:0] UPTIME_OFFSET = 40'd5000;
  localparam int BUCKET_SHR = 4;
  localparam int DVD_W = UPTIME_W - BUCKET_SHR;
  localparam int REM_W = 10;
  localparam logic [REM_W-1:0] BUCKET_DIVISOR = 10'd625;

  // bucket digits of 9 bits: digit = floor(t / 625) = (t * ceil(2^29 / 625)) >> 29,
  // exact for t below 625 * 512; the last digit holds the bucket modulo 256
  localparam int BKT_DIGIT_W = 9;
  localparam int BKT_T_W = REM_W + BKT_DIGIT_W;
  localparam int BKT_RECIP_W = 20;
  localparam logic [BKT_RECIP_W-1:0] BKT_RECIP = 20'd858994;
  localparam int BKT_PROD_W = BKT_T_W + BKT_RECIP_W;
  localparam int BKT_SHR = 29;

  // step counts of the bucket unit and the serial modulo
  localparam int BUCKET_STEPS = DVD_W / BKT_DIGIT_W;
  localparam int MOD_STEPS = 8;
  localparam int CNT_W = $clog2(MOD_STEPS);

  // controller to datapath commands
  typedef struct packed {
    logic load_first;
    logic encode_direct;
    logic encode_held;
    logic div_step;
    logic bkt_step;
    logic mod_init;
    logic pick;
    logic finish;
  } trx_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic size_two;
    logic out_busy;
  } trx_sts_t;

endpackage

// ===== design/trx_in_if.sv =====
// input byte channel of the codec
interface trx_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 first;
  logic [trx_pkg::UPTIME_W-1:0]         uptime_ms;
  logic [7:0]                           plain_byte;
  logic                                 last;

  modport source (output valid, first, uptime_ms, plain_byte, last, input ready);
  modport sink (input valid, first, uptime_ms, plain_byte, last, output ready);
endinterface

// ===== design/trx_out_if.sv =====
// result byte channel of the codec
interface trx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       last_out;

  modport source (output valid, cipher_byte, last_out, input ready);
  modport sink (input valid, cipher_byte, last_out, output ready);
endinterface

// ===== design/trx_dp.sv =====
// codec datapath: bucket unit, serial modulo, key pool, rolling key and output register
module trx_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trx_pkg::trx_cmd_t             cmd,
  output trx_pkg::trx_sts_t             sts,
  input  logic [trx_pkg::UPTIME_W-1:0]  in_uptime_ms,
  input  logic [7:0]                    in_plain_byte,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [7:0]                    out_cipher_byte,
  output logic                          out_last_out
);

  // divider state
  logic [trx_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [trx_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [trx_pkg::REM_W-1:0]  div_r, div_nxt;
  logic [trx_pkg::REM_W:0]    trial;
  logic [trx_pkg::REM_W:0]    diff;
  logic                       q_bit;

  // bucket digit unit
  logic [trx_pkg::BKT_T_W-1:0]     bkt_t;
  logic [trx_pkg::BKT_PROD_W-1:0]  bkt_prod;
  logic [trx_pkg::BKT_DIGIT_W-1:0] bkt_digit;
  logic [trx_pkg::BKT_T_W-1:0]     bkt_rem;

  // key derivation state
  trx_pkg::trx_byte_t         n_r, n_nxt;
  trx_pkg::trx_byte_t         pool_r [trx_pkg::KEY_LEN];
  trx_pkg::trx_byte_t         pool_nxt [trx_pkg::KEY_LEN];
  logic [trx_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [trx_pkg::KEY_IDX_W-1:0] pick_idx;
  trx_pkg::trx_byte_t         pick_val;
  logic [16:0]                prod;
  logic [trx_pkg::UPTIME_W-1:0] excess;

  // rolling key and message state
  trx_pkg::trx_byte_t         key_r [trx_pkg::KEY_LEN];
  trx_pkg::trx_byte_t         key_nxt [trx_pkg::KEY_LEN];
  trx_pkg::trx_byte_t         pos_r, pos_nxt;
  trx_pkg::trx_byte_t         plain_r, plain_nxt;
  logic                       last_r, last_nxt;

  // encoder
  trx_pkg::trx_byte_t         enc_plain;
  logic                       enc_last;
  trx_pkg::trx_byte_t         enc_cipher;
  trx_pkg::trx_byte_t         enc_key1;
  logic                       enc_en;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  trx_pkg::trx_byte_t         out_cipher_r, out_cipher_nxt;
  logic                       out_last_r, out_last_nxt;

  // one restoring division step
  assign trial = {rem_r, dvd_r[trx_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign q_bit = (trial >= {1'b0, div_r});

  // one bucket digit: divide remainder and next 9 bits by 625
  assign bkt_t     = {rem_r, dvd_r[trx_pkg::DVD_W-1 -: trx_pkg::BKT_DIGIT_W]};
  assign bkt_prod  = trx_pkg::BKT_PROD_W'(bkt_t) * trx_pkg::BKT_PROD_W'(trx_pkg::BKT_RECIP);
  assign bkt_digit = bkt_prod[trx_pkg::BKT_SHR +: trx_pkg::BKT_DIGIT_W];
  assign bkt_rem   = bkt_t - trx_pkg::BKT_T_W'(bkt_digit) *
                             trx_pkg::BKT_T_W'(trx_pkg::BUCKET_DIVISOR);

  // pool pick and next n = (n * v + v) mod 256
  assign pick_idx = rem_r[trx_pkg::KEY_IDX_W-1:0];
  assign pick_val = pool_r[pick_idx];
  assign prod     = 17'({1'b0, n_r} + 9'd1) * 17'(pick_val);

  // uptime offset clamped at zero
  assign excess = (in_uptime_ms > trx_pkg::UPTIME_OFFSET) ?
                  (in_uptime_ms - trx_pkg::UPTIME_OFFSET) : '0;

  // encode source: direct input or held first byte
  assign enc_en     = cmd.encode_direct | cmd.encode_held;
  assign enc_plain  = cmd.encode_held ? plain_r : in_plain_byte;
  assign enc_last   = cmd.encode_held ? last_r : in_last;
  assign enc_cipher = enc_plain ^ key_r[0];
  assign enc_key1   = (key_r[1] ^ enc_cipher) + pos_r;

  // next-state logic
  always_comb begin
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    n_nxt     = n_r;
    size_nxt  = size_r;
    pos_nxt   = pos_r;
    plain_nxt = plain_r;
    last_nxt  = last_r;
    for (int j = 0; j < trx_pkg::KEY_LEN; j++) begin
      pool_nxt[j] = pool_r[j];
      key_nxt[j]  = key_r[j];
    end

    if (cmd.load_first) begin
      dvd_nxt   = excess[trx_pkg::UPTIME_W-1:trx_pkg::BUCKET_SHR];
      rem_nxt   = '0;
      size_nxt  = trx_pkg::SIZE_W'(trx_pkg::KEY_LEN);
      pos_nxt   = '0;
      plain_nxt = in_plain_byte;
      last_nxt  = in_last;
      for (int j = 0; j < trx_pkg::KEY_LEN; j++) begin
        pool_nxt[j] = trx_pkg::BASE_KEY[j];
      end
    end

    // bucket digit; the last one leaves the bucket modulo 256 in n
    if (cmd.bkt_step) begin
      dvd_nxt = {dvd_r[trx_pkg::DVD_W-trx_pkg::BKT_DIGIT_W-1:0],
                 {trx_pkg::BKT_DIGIT_W{1'b0}}};
      rem_nxt = bkt_rem[trx_pkg::REM_W-1:0];
      n_nxt   = bkt_digit[7:0];
    end

    if (cmd.div_step) begin
      dvd_nxt = {dvd_r[trx_pkg::DVD_W-2:0], 1'b0};
      rem_nxt = q_bit ? diff[trx_pkg::REM_W-1:0] : trial[trx_pkg::REM_W-1:0];
    end

    // reduce n modulo the current pool size
    if (cmd.mod_init) begin
      dvd_nxt = {n_r, {(trx_pkg::DVD_W-8){1'b0}}};
      rem_nxt = '0;
      div_nxt = trx_pkg::REM_W'(size_r);
    end

    // take one entry out of the pool and shift it into the key
    if (cmd.pick) begin
      for (int j = 0; j < trx_pkg::KEY_LEN - 1; j++) begin
        if (j >= int'(pick_idx)) begin
          pool_nxt[j] = pool_r[j+1];
        end
        key_nxt[j] = key_r[j+1];
      end
      key_nxt[trx_pkg::KEY_LEN-1] = pick_val ^ n_r;
      n_nxt    = prod[7:0];
      size_nxt = size_r - trx_pkg::SIZE_W'(1);
    end

    // last remaining pool entry completes the key
    if (cmd.finish) begin
      for (int j = 0; j < trx_pkg::KEY_LEN - 1; j++) begin
        key_nxt[j] = key_r[j+1];
      end
      key_nxt[trx_pkg::KEY_LEN-1] = pool_r[0];
    end

    // encode and rotate so slot 0 holds the next position's key byte
    if (enc_en) begin
      key_nxt[0] = enc_key1;
      for (int j = 1; j < trx_pkg::KEY_LEN - 1; j++) begin
        key_nxt[j] = key_r[j+1];
      end
      key_nxt[trx_pkg::KEY_LEN-1] = key_r[0];
      pos_nxt = pos_r + 8'd1;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_cipher_nxt = out_cipher_r;
    out_last_nxt   = out_last_r;
    if (enc_en) begin
      out_valid_nxt  = 1'b1;
      out_cipher_nxt = enc_cipher;
      out_last_nxt   = enc_last;
    end
  end

  // control state and rolling key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      for (int j = 0; j < trx_pkg::KEY_LEN; j++) begin
        key_r[j] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      for (int j = 0; j < trx_pkg::KEY_LEN; j++) begin
        key_r[j] <= key_nxt[j];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    n_r          <= n_nxt;
    size_r       <= size_nxt;
    plain_r      <= plain_nxt;
    last_r       <= last_nxt;
    out_cipher_r <= out_cipher_nxt;
    out_last_r   <= out_last_nxt;
    for (int j = 0; j < trx_pkg::KEY_LEN; j++) begin
      pool_r[j] <= pool_nxt[j];
    end
  end

  assign sts.size_two     = (size_r == trx_pkg::SIZE_W'(2));
  assign sts.out_busy     = out_valid_r & ~out_ready;
  assign out_valid        = out_valid_r;
  assign out_cipher_byte  = out_cipher_r;
  assign out_last_out     = out_last_r;

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.div_step) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // picked index lies inside the live pool
  a_pick_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |-> (rem_r < trx_pkg::REM_W'(size_r)) && (size_r >= trx_pkg::SIZE_W'(2)))
    else $error("pool pick outside live entries");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    enc_en |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten");

endmodule

// ===== design/trx_ctrl.sv =====
// codec controller: sequences key derivation and encoding
module trx_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_first,
  output logic               in_ready,
  input  trx_pkg::trx_sts_t  sts,
  output trx_pkg::trx_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUCKET,
    ST_MOD_INIT,
    ST_MOD,
    ST_PICK,
    ST_FINISH,
    ST_ENC
  } state_t;

  state_t                    state_r, state_nxt;
  logic [trx_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      accept;

  assign in_ready = (state_r == ST_IDLE) && !sts.out_busy;
  assign accept   = in_valid && in_ready;

  // commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_first) begin
            cmd.load_first = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = ST_BUCKET;
          end else begin
            cmd.encode_direct = 1'b1;
          end
        end
      end
      ST_BUCKET: begin
        cmd.bkt_step = 1'b1;
        cnt_nxt      = cnt_r + trx_pkg::CNT_W'(1);
        if (cnt_r == trx_pkg::CNT_W'(trx_pkg::BUCKET_STEPS - 1)) begin
          state_nxt = ST_MOD_INIT;
        end
      end
      ST_MOD_INIT: begin
        cmd.mod_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MOD;
      end
      ST_MOD: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + trx_pkg::CNT_W'(1);
        if (cnt_r == trx_pkg::CNT_W'(trx_pkg::MOD_STEPS - 1)) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = sts.size_two ? ST_FINISH : ST_MOD_INIT;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_ENC;
      end
      ST_ENC: begin
        if (!sts.out_busy) begin
          cmd.encode_held = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // a message start holds off the next request while the key is derived
  a_first_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_first) |=> !in_ready)
    else $error("request accepted during key derivation");

  // encoding only happens from idle or after derivation completes
  a_enc_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.encode_held |-> $past(state_r == ST_FINISH) || $past(state_r == ST_ENC))
    else $error("held byte encoded before key finished");

endmodule

// ===== design/timed_key_rolling_xor_codec.sv =====
// top level of the timed-key rolling xor byte codec
// Encodes a byte stream with a rolling 8-byte xor key. A request with first set
// starts a message: the key is derived from uptime_ms (bucket of 10 s after a
// 5 s offset) and the byte position restarts at zero before that byte is
// encoded. Every request yields exactly one result, with last_out copied from
// last. A request without first is encoded in the cycle it is accepted, and the block
// accepts one such request per cycle while the output register drains. A request with
// first holds off every new request until its result is formed, and no new
// request is accepted meanwhile: the uptime bucket is formed in 4 steps that each take
// 9 more uptime bits and divide by 625 with a reciprocal multiply, then for
// each of the seven pool picks one load, 8 steps of a bit-serial modulo by the
// pool size and the pick itself, then the last key byte is placed and the byte
// is encoded once the output register is free. After reset the key is all zero and the position is
// zero, so bytes sent before any first are encoded with that key.
module timed_key_rolling_xor_codec (
  input  logic        clk,
  input  logic        rst_n,
  trx_in_if.sink      in_ch,
  trx_out_if.source   out_ch
);

  trx_pkg::trx_cmd_t cmd;
  trx_pkg::trx_sts_t sts;

  // sequencing
  trx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_first (in_ch.first),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // key derivation and encoding
  trx_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_uptime_ms    (in_ch.uptime_ms),
    .in_plain_byte   (in_ch.plain_byte),
    .in_last         (in_ch.last),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_cipher_byte (out_ch.cipher_byte),
    .out_last_out    (out_ch.last_out)
  );

endmodule

// ===== bench/tb_timed_key_rolling_xor_codec.sv =====
// self-checking testbench of the timed-key rolling xor byte codec
module tb_timed_key_rolling_xor_codec;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UP_W = trx_pkg::UPTIME_W;
  localparam int RANDOM_BYTES = 1600;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 130;
  localparam int EXP_DEPTH = 256;
  localparam logic [UP_W-1:0] UPTIME_MAX = {UP_W{1'b1}};
  localparam logic [7:0] MARKER = 8'hFF;
  localparam logic [7:0] SEED_KEY [8] = '{
    8'h8F, 8'h80, 8'h19, 8'hCF, 8'h77, 8'h6C, 8'hFE, 8'hB7
  };

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_out;
  } cipher_rec_t;

  logic clk;
  logic rst_n;

  trx_in_if  in_if ();
  trx_out_if out_if ();

  timed_key_rolling_xor_codec dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor state
  logic [7:0]  key_q [8];
  logic [7:0]  pos_q;
  cipher_rec_t exp_mem [EXP_DEPTH];
  int          exp_wr;
  int          exp_rd;

  int err_count;
  int bytes_sent;
  int burst_left;
  int idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // predicted results in request order
  task automatic store_expected(input cipher_rec_t rec);
    exp_mem[exp_wr % EXP_DEPTH] = rec;
    exp_wr++;
  endtask

  // key derivation from the uptime bucket
  function automatic void derive_rolling_key(input logic [UP_W-1:0] up);
    logic [UP_W-1:0] n;
    logic [7:0] pool [8];
    logic [7:0] v;
    int size;
    int idx;
    n = (up > 40'd5000) ? (up - 40'd5000) / 40'd10000 : '0;
    for (int j = 0; j < 8; j++) pool[j] = SEED_KEY[j];
    for (size = 8; size > 1; size--) begin
      idx = int'(n % UP_W'(size));
      v = pool[idx];
      for (int j = idx; j + 1 < size; j++) pool[j] = pool[j + 1];
      key_q[8 - size] = v ^ n[7:0];
      n = (n * v + v) & 40'hFF;
    end
    key_q[7] = pool[0];
  endfunction

  // one encoded byte and the key update it causes
  function automatic cipher_rec_t roll_cipher(input logic f, input logic [UP_W-1:0] up,
                                              input logic [7:0] plain, input logic l);
    cipher_rec_t rec;
    logic [7:0] i;
    logic [2:0] nx;
    if (f) begin
      derive_rolling_key(up);
      pos_q = '0;
    end
    i = pos_q;
    rec.cipher_byte = plain ^ key_q[i[2:0]];
    rec.last_out = l;
    nx = i[2:0] + 3'd1;
    key_q[nx] = (key_q[nx] ^ rec.cipher_byte) + i;
    pos_q = i + 8'd1;
    return rec;
  endfunction

  // send one request, with random bursts and gaps
  task automatic send_byte(input logic f, input logic [UP_W-1:0] up,
                           input logic [7:0] plain, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(3) != 0) begin
        gap = $urandom_range(1, 12);
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.first      <= f;
    in_if.uptime_ms  <= up;
    in_if.plain_byte <= plain;
    in_if.last       <= l;
    do @(posedge clk); while (!in_if.ready);
    store_expected(roll_cipher(f, up, plain, l));
    burst_left--;
    bytes_sent++;
  endtask

  function automatic logic [UP_W-1:0] pick_uptime();
    logic [UP_W-1:0] u;
    int unsigned k;
    case ($urandom_range(3))
      0: u = UP_W'($urandom_range(20000));
      1: begin
        k = $urandom_range(100000);
        u = UP_W'(k) * 40'd10000 + 40'd5000 + UP_W'($urandom_range(2)) - 40'd1;
      end
      2: u = {8'($urandom), 32'($urandom)};
      default: u = UPTIME_MAX - UP_W'($urandom_range(30000));
    endcase
    return u;
  endfunction

  function automatic logic [7:0] pick_plain();
    return ($urandom_range(7) == 0) ? MARKER : 8'($urandom);
  endfunction

  // one message: first on the opening byte, last on the closing one
  task automatic send_message(input logic [UP_W-1:0] up, input int len);
    for (int i = 0; i < len; i++)
      send_byte(i == 0, (i == 0) ? up : {8'($urandom), 32'($urandom)}, pick_plain(),
                i == len - 1);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (exp_wr != exp_rd);
  endtask

  // bytes before any first use the all-zero reset key
  task automatic test_before_first();
    send_byte(1'b0, 40'd0, 8'h00, 1'b0);
    send_byte(1'b0, UPTIME_MAX, 8'hFF, 1'b0);
    send_byte(1'b0, 40'd12345, 8'hA5, 1'b0);
    send_byte(1'b0, 40'd0, 8'h5A, 1'b1);
  endtask

  // bucket edges, the zero bucket below the offset and the largest uptime
  task automatic test_uptime_edges();
    send_message(40'd0, 2);
    send_message(40'd4999, 2);
    send_message(40'd5000, 2);
    send_message(40'd5001, 2);
    send_message(40'd14999, 2);
    send_message(40'd15000, 2);
    send_message(UPTIME_MAX, 3);
    send_byte(1'b1, 40'd25000, MARKER, 1'b1);
  endtask

  // after last the key stream runs on; a first mid-message restarts it
  task automatic test_after_last_and_restart();
    send_byte(1'b0, 40'd0, 8'h00, 1'b0);
    send_byte(1'b0, 40'd0, 8'hFF, 1'b1);
    send_byte(1'b1, 40'd987654, 8'h11, 1'b0);
    send_byte(1'b1, 40'd987654, 8'h22, 1'b0);
    send_byte(1'b0, 40'd0, 8'h33, 1'b1);
  endtask

  // position wraps past 255
  task automatic test_long_message();
    send_message(pick_uptime(), 300);
  endtask

  // sender holds off until every result is back
  task automatic test_drain_pause();
    drain_results();
    send_message(pick_uptime(), 6);
    drain_results();
  endtask

  // mostly well-formed messages, some noise and broken framing
  task automatic test_random_messages();
    int len;
    while (bytes_sent < RANDOM_BYTES) begin
      case ($urandom_range(19))
        0, 1: send_byte(1'($urandom_range(1)), {8'($urandom), 32'($urandom)},
                        8'($urandom), 1'($urandom_range(1)));
        2: send_message(pick_uptime(), $urandom_range(40, 90));
        default: begin
          len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
          send_message(pick_uptime(), len);
        end
      endcase
    end
  endtask

  // receiver ready pattern
  initial begin
    rx_mode_t mode;
    int left;
    mode = RX_OPEN;
    left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(3));
        left = (mode == RX_HOLD) ? $urandom_range(1, 16) : $urandom_range(10, 80);
      end
      left--;
      case (mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(1));
        RX_SPARSE: out_if.ready <= ($urandom_range(3) == 0);
        default:   out_if.ready <= 1'b0;
      endcase
    end
  end

  // result checking against the oldest prediction
  always @(posedge clk) begin : check_results
    cipher_rec_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (exp_wr == exp_rd) begin
        report_mismatch($sformatf("result %h with nothing pending", out_if.cipher_byte));
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_if.cipher_byte !== want.cipher_byte)
          report_mismatch($sformatf("cipher_byte got %h want %h",
                                    out_if.cipher_byte, want.cipher_byte));
        if (out_if.last_out !== want.last_out)
          report_mismatch($sformatf("last_out got %b want %b",
                                    out_if.last_out, want.last_out));
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // reset, tests in turn, final drain
  initial begin
    for (int j = 0; j < 8; j++) key_q[j] = '0;
    pos_q = '0;
    exp_wr = 0;
    exp_rd = 0;
    err_count = 0;
    bytes_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.first      <= 1'b0;
    in_if.uptime_ms  <= '0;
    in_if.plain_byte <= '0;
    in_if.last       <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_first();
    test_uptime_edges();
    test_after_last_and_restart();
    test_drain_pause();
    test_long_message();
    test_random_messages();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/trx_pkg.sv
design/trx_in_if.sv
design/trx_out_if.sv
design/trx_dp.sv
design/trx_ctrl.sv
design/timed_key_rolling_xor_codec.sv
bench/tb_timed_key_rolling_xor_codec.sv
